// ===== rtl/core/rbsi_pkg.sv =====
package rbsi_pkg;

   localparam int COORD_WIDTH     = 32;
   localparam int PARAM_FRAC_BITS = 16;

   localparam int CW = COORD_WIDTH;
   // slab parameter: signed, spans -1 ulp .. 1.0 + 1 ulp
   localparam int TW = PARAM_FRAC_BITS + 2;
   localparam int OW = PARAM_FRAC_BITS + 1;

   localparam int NUM_AXES = 3;

   localparam logic [TW-1:0] T_ONE     = TW'(1) << PARAM_FRAC_BITS;
   localparam logic [TW-1:0] T_BEYOND  = T_ONE + TW'(1);

   // divider: magnitude stage, integer stage, one stage per fraction bit, finish
   localparam int DIV_LAT  = PARAM_FRAC_BITS + 3;
   // lane: difference register, divider, ordering register
   localparam int LANE_LAT = DIV_LAT + 2;
   // merge: min/max register, result register
   localparam int LATENCY  = LANE_LAT + 2;

   typedef struct packed {
      logic signed [CW-1:0] origin_x;
      logic signed [CW-1:0] origin_y;
      logic signed [CW-1:0] origin_z;
      logic signed [CW-1:0] dir_x;
      logic signed [CW-1:0] dir_y;
      logic signed [CW-1:0] dir_z;
      logic signed [CW-1:0] box_min_x;
      logic signed [CW-1:0] box_min_y;
      logic signed [CW-1:0] box_min_z;
      logic signed [CW-1:0] box_max_x;
      logic signed [CW-1:0] box_max_y;
      logic signed [CW-1:0] box_max_z;
   } rbsi_req_type;

   typedef struct packed {
      logic          hit;
      logic [OW-1:0] entry_param;
   } rbsi_rsp_type;

   // what one axis lane hands to the merge stage
   typedef struct packed {
      logic                 ok;
      logic signed [TW-1:0] t_enter;
      logic signed [TW-1:0] t_exit;
   } rbsi_lane_type;

endpackage

// ===== rtl/core/rbsi_div.sv =====
module rbsi_div
   import rbsi_pkg::*;
(
   input  logic                 clock,
   input  logic signed [CW:0]   n_in,
   input  logic signed [CW-1:0] d_in,
   output logic signed [TW-1:0] t_out
);

   localparam int PFB = PARAM_FRAC_BITS;

   logic [CW-1:0] un_ff;
   logic [CW-1:0] ud_ff  [0:PFB];
   logic          neg_ff [0:PFB+1];
   logic          sat_ff [1:PFB+1];
   logic [CW-1:0] r_ff   [1:PFB];
   logic [PFB:0]  m_ff   [1:PFB+1];
   logic signed [TW-1:0] t_ff;

   logic [CW:0]   un_full;
   logic [CW-1:0] ud_full;
   logic          sat_in;
   logic          ge_in;
   logic [CW-1:0] r0_in;
   logic [TW-1:0] mag;
   logic signed [TW-1:0] t_in;

   // magnitudes and sign of the quotient
   always_comb begin
      un_full = n_in[CW] ? (-n_in) : n_in;
      ud_full = d_in[CW-1] ? (-d_in) : d_in;
   end

   always_ff @(posedge clock) begin
      un_ff     <= un_full[CW-1:0];
      ud_ff[0]  <= ud_full;
      neg_ff[0] <= n_in[CW] ^ d_in[CW-1];
   end

   // integer bit and saturation at two or more
   always_comb begin
      sat_in = {1'b0, un_ff} >= {ud_ff[0], 1'b0};
      ge_in  = un_ff >= ud_ff[0];
      r0_in  = ge_in ? (un_ff - ud_ff[0]) : un_ff;
   end

   always_ff @(posedge clock) begin
      ud_ff[1]  <= ud_ff[0];
      neg_ff[1] <= neg_ff[0];
      sat_ff[1] <= sat_in;
      r_ff[1]   <= r0_in;
      m_ff[1]   <= {{PFB{1'b0}}, ge_in};
   end

   // one fraction bit per stage
   for (genvar k = 1; k <= PFB; k++) begin : g_frac
      logic [CW:0]   rs;
      logic          take;

      always_comb begin
         rs   = {r_ff[k], 1'b0};
         take = rs >= {1'b0, ud_ff[k]};
      end

      always_ff @(posedge clock) begin
         neg_ff[k+1] <= neg_ff[k];
         sat_ff[k+1] <= sat_ff[k];
         m_ff[k+1]   <= {m_ff[k][PFB-1:0], take};
      end

      // remainder and divisor only go on while bits are left to find
      if (k < PFB) begin : g_rem
         logic [CW-1:0] diff;

         always_comb begin
            diff = rs[CW-1:0] - ud_ff[k];
         end

         always_ff @(posedge clock) begin
            ud_ff[k+1] <= ud_ff[k];
            r_ff[k+1]  <= take ? diff : rs[CW-1:0];
         end
      end
   end

   // clamp above 1.0, fold negatives to -1 ulp or zero
   always_comb begin
      if (sat_ff[PFB+1] || ({1'b0, m_ff[PFB+1]} > T_ONE)) begin
         mag = T_BEYOND;
      end else begin
         mag = {1'b0, m_ff[PFB+1]};
      end
      if (neg_ff[PFB+1]) begin
         t_in = (mag != '0) ? '1 : '0;
      end else begin
         t_in = $signed(mag);
      end
   end

   always_ff @(posedge clock) begin
      t_ff <= t_in;
   end

   assign t_out = t_ff;

endmodule

// ===== rtl/core/rbsi_lane.sv =====
module rbsi_lane
   import rbsi_pkg::*;
(
   input  logic                 clock,
   input  logic signed [CW-1:0] origin,
   input  logic signed [CW-1:0] dir,
   input  logic signed [CW-1:0] box_min,
   input  logic signed [CW-1:0] box_max,
   output rbsi_lane_type        lane_out
);

   logic signed [CW:0]   dlo_ff;
   logic signed [CW:0]   dhi_ff;
   logic signed [CW-1:0] dir_ff;
   logic                 zdir_ff [0:DIV_LAT];
   logic                 inside_ff [0:DIV_LAT];
   logic signed [TW-1:0] t0;
   logic signed [TW-1:0] t1;
   rbsi_lane_type        lane_in;
   rbsi_lane_type        lane_ff;

   always_ff @(posedge clock) begin
      dlo_ff       <= {box_min[CW-1], box_min} - {origin[CW-1], origin};
      dhi_ff       <= {box_max[CW-1], box_max} - {origin[CW-1], origin};
      dir_ff       <= dir;
      zdir_ff[0]   <= dir == '0;
      inside_ff[0] <= !(origin < box_min) && !(origin > box_max);
   end

   // flags ride alongside the divider pipeline
   for (genvar s = 1; s <= DIV_LAT; s++) begin : g_dly
      always_ff @(posedge clock) begin
         zdir_ff[s]   <= zdir_ff[s-1];
         inside_ff[s] <= inside_ff[s-1];
      end
   end

   rbsi_div u_div_lo (
      .clock (clock),
      .n_in  (dlo_ff),
      .d_in  (dir_ff),
      .t_out (t0)
   );

   rbsi_div u_div_hi (
      .clock (clock),
      .n_in  (dhi_ff),
      .d_in  (dir_ff),
      .t_out (t1)
   );

   // zero direction leaves the interval alone, or kills it
   always_comb begin
      if (zdir_ff[DIV_LAT]) begin
         lane_in.ok      = inside_ff[DIV_LAT];
         lane_in.t_enter = '0;
         lane_in.t_exit  = $signed(T_ONE);
      end else begin
         lane_in.ok      = 1'b1;
         lane_in.t_enter = (t0 > t1) ? t1 : t0;
         lane_in.t_exit  = (t0 > t1) ? t0 : t1;
      end
   end

   always_ff @(posedge clock) begin
      lane_ff <= lane_in;
   end

   assign lane_out = lane_ff;

endmodule

// ===== rtl/core/rbsi_merge.sv =====
module rbsi_merge
   import rbsi_pkg::*;
(
   input  logic                                clock,
   input  rbsi_lane_type [NUM_AXES-1:0]        lane_in,
   output rbsi_rsp_type                        rsp_out
);

   logic signed [TW-1:0] tmin_in;
   logic signed [TW-1:0] tmax_in;
   logic                 ok_in;
   logic signed [TW-1:0] tmin_ff;
   logic signed [TW-1:0] tmax_ff;
   logic                 ok_ff;
   rbsi_rsp_type         rsp_in;
   rbsi_rsp_type         rsp_ff;

   always_comb begin
      tmin_in = '0;
      tmax_in = $signed(T_ONE);
      ok_in   = 1'b1;
      for (int i = 0; i < NUM_AXES; i++) begin
         if ($signed(lane_in[i].t_enter) > tmin_in) begin
            tmin_in = lane_in[i].t_enter;
         end
         if ($signed(lane_in[i].t_exit) < tmax_in) begin
            tmax_in = lane_in[i].t_exit;
         end
         ok_in = ok_in && lane_in[i].ok;
      end
   end

   always_ff @(posedge clock) begin
      tmin_ff <= tmin_in;
      tmax_ff <= tmax_in;
      ok_ff   <= ok_in;
   end

   always_comb begin
      rsp_in.hit         = ok_ff && (tmin_ff <= tmax_ff);
      rsp_in.entry_param = rsp_in.hit ? tmin_ff[OW-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_out = rsp_ff;

endmodule

// ===== rtl/core/ray_box_slab_intersect_top.sv =====
// Segment against axis-aligned box, slab test over x, y and z in signed
// Q15.16. A request transfers when start is high and busy is low; busy is
// never raised, so one test may be started on every clock. The result
// (hit, entry parameter with 65536 = 1.0, zero on a miss) appears on
// rsp_data for exactly one cycle with rsp_valid high, in request order.
// The receiver cannot stall it. The pipeline runs through the pipelined
// restoring dividers: one stage for the magnitudes, one for the integer
// bit and saturation, one stage per fraction bit and one for the clamp,
// plus difference, ordering and two merge registers.
// Three axis lanes run side by side, each with two dividers (box_min and
// box_max plane); a merge stage narrows [0, 1] over the three lanes.
module ray_box_slab_intersect_top
   import rbsi_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  rbsi_req_type  req_data,
   output logic          rsp_valid,
   output rbsi_rsp_type  rsp_data
);

   logic                         accept;
   logic [LATENCY-1:0]           vld_ff;
   logic [LATENCY-1:0]           vld_in;
   rbsi_lane_type [NUM_AXES-1:0] lanes;

   // fully pipelined, never holds the requester off
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // strobe tracks each transfer through the pipeline
   assign vld_in = {vld_ff[LATENCY-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign rsp_valid = vld_ff[LATENCY-1];

   rbsi_lane u_lane_x (
      .clock    (clock),
      .origin   (req_data.origin_x),
      .dir      (req_data.dir_x),
      .box_min  (req_data.box_min_x),
      .box_max  (req_data.box_max_x),
      .lane_out (lanes[0])
   );

   rbsi_lane u_lane_y (
      .clock    (clock),
      .origin   (req_data.origin_y),
      .dir      (req_data.dir_y),
      .box_min  (req_data.box_min_y),
      .box_max  (req_data.box_max_y),
      .lane_out (lanes[1])
   );

   rbsi_lane u_lane_z (
      .clock    (clock),
      .origin   (req_data.origin_z),
      .dir      (req_data.dir_z),
      .box_min  (req_data.box_min_z),
      .box_max  (req_data.box_max_z),
      .lane_out (lanes[2])
   );

   // interval narrowing and final hit decision
   rbsi_merge u_merge (
      .clock   (clock),
      .lane_in (lanes),
      .rsp_out (rsp_data)
   );

endmodule

// ===== rtl/core/rbsi_checker.sv =====
module rbsi_checker
   import rbsi_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input rbsi_rsp_type rsp_data,
   input logic         rsp_valid
);

   a_no_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("busy raised");

   a_strobe_follows_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without matching request");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.hit) |-> (rsp_data.entry_param == '0))
      else $error("miss with non-zero entry parameter");

   a_entry_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.hit) |-> (rsp_data.entry_param <= T_ONE[OW-1:0]))
      else $error("entry parameter beyond 1.0");

endmodule

bind ray_box_slab_intersect_top rbsi_checker u_rbsi_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_data  (rsp_data),
   .rsp_valid (rsp_valid)
);
